// File: rtl/awt_pkg.sv
// awt_pkg: shared types and constants of the ASCII word tokenizer.
// Used by every module of the block except awt_ram; depends on nothing.
package awt_pkg;

  localparam int CFG_W      = 7;
  localparam int POS_W      = 32;
  localparam int DESC_IDX_W = 6;   // covers the largest supported token buffer
  localparam int DESC_LEN_W = 7;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_MIN_LEN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LEN = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BUMPER  = 2'd2;

  localparam logic [CFG_W-1:0] MIN_LEN_RST = 7'd1;
  localparam logic [CFG_W-1:0] MAX_LEN_RST = 7'd64;
  localparam logic [CFG_W-1:0] BUMPER_RST  = 7'd0;

  localparam logic [CFG_W-1:0] CH_APOS  = 7'h27;
  localparam logic [CFG_W-1:0] CH_UP_A  = 7'h41;
  localparam logic [CFG_W-1:0] CH_UP_Z  = 7'h5A;
  localparam logic [CFG_W-1:0] CH_LO_A  = 7'h61;
  localparam logic [CFG_W-1:0] CH_LO_Z  = 7'h7A;
  localparam logic [CFG_W-1:0] CH_D0    = 7'h30;
  localparam logic [CFG_W-1:0] CH_D9    = 7'h39;
  localparam logic [CFG_W-1:0] CASE_BIT = 7'h20;

  typedef struct packed {
    logic [CFG_W-1:0] min_len;
    logic [CFG_W-1:0] max_len;
    logic [CFG_W-1:0] bumper;
  } cfg_t;

  // One finished token waiting to be streamed out.
  typedef struct packed {
    logic                  half;
    logic [DESC_IDX_W-1:0] start;
    logic [DESC_LEN_W-1:0] len;
    logic [POS_W-1:0]      pos;
  } desc_t;

  // Buffer half handed back once its token has left the block.
  typedef struct packed {
    logic valid;
    logic half;
  } rel_t;

endpackage

// File: rtl/awt_ram.sv
// awt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module awt_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/awt_front.sv
// awt_front: accepts characters, builds tokens into the buffer RAM, tracks
// apostrophe stripping and the position counter, and queues finished tokens.
// Depends on awt_pkg.
module awt_front import awt_pkg::*; #(
  parameter int MAX_TOKEN = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cfg_t                                 cfg,
  input  logic                                 char_valid,
  output logic                                 char_stall,
  input  logic [CFG_W-1:0]                     char_code,
  input  logic                                 end_of_text,
  output logic                                 ram_we,
  output logic [$clog2(MAX_TOKEN):0]           ram_waddr,
  output logic [CFG_W-1:0]                     ram_wdata,
  output logic                                 push,
  output desc_t                                desc,
  input  rel_t                                 rel
);

  localparam int IDXW = $clog2(MAX_TOKEN);
  localparam int LENW = $clog2(MAX_TOKEN + 1);

  logic            inside_tok;
  logic [LENW-1:0] tok_len;
  logic            have_na;    // token holds a non-apostrophe character
  logic [LENW-1:0] s_idx;      // first non-apostrophe index
  logic [LENW-1:0] e_idx;      // one past last non-apostrophe index
  logic            wr_half;
  logic [POS_W-1:0] pos;
  logic [1:0]      busy;

  logic [CFG_W-1:0] c_low, eff_max, eff_min;
  logic            accept, word, fin, emit, bump;
  logic [LENW-1:0] i_cur, l_new, s_cur, e_cur, s_new, e_new, s_f, e_f, strip;
  logic            have_cur, have_new, have_f;

  assign char_stall = busy[wr_half];
  assign accept     = char_valid && !char_stall;

  always_comb begin
    c_low = char_code;
    if (char_code inside {[CH_UP_A:CH_UP_Z]}) begin
      c_low = char_code | CASE_BIT;
    end
    word = c_low inside {[CH_LO_A:CH_LO_Z], [CH_D0:CH_D9], CH_APOS};

    eff_max = cfg.max_len;
    if (cfg.max_len == '0) begin
      eff_max = CFG_W'(1);
    end else if (cfg.max_len > CFG_W'(MAX_TOKEN)) begin
      eff_max = CFG_W'(MAX_TOKEN);
    end
    eff_min = (cfg.min_len == '0) ? CFG_W'(1) : cfg.min_len;

    i_cur    = inside_tok ? tok_len : '0;
    have_cur = inside_tok && have_na;
    s_cur    = s_idx;
    e_cur    = e_idx;
    l_new    = i_cur + LENW'(1);

    if (c_low != CH_APOS) begin
      have_new = 1'b1;
      s_new    = have_cur ? s_cur : i_cur;
      e_new    = l_new;
    end else begin
      have_new = have_cur;
      s_new    = s_cur;
      e_new    = e_cur;
    end

    if (word) begin
      fin    = accept && (CFG_W'(l_new) >= eff_max || end_of_text);
      have_f = have_new;
      s_f    = s_new;
      e_f    = e_new;
    end else begin
      fin    = accept && inside_tok;
      have_f = have_cur;
      s_f    = s_cur;
      e_f    = e_cur;
    end

    strip = e_f - s_f;
    emit  = fin && have_f && (CFG_W'(strip) >= eff_min);
    bump  = accept && (cfg.bumper != '0) && (c_low == cfg.bumper);
  end

  assign ram_we    = accept && word;
  assign ram_waddr = {wr_half, i_cur[IDXW-1:0]};
  assign ram_wdata = c_low;

  assign push       = emit;
  assign desc.half  = wr_half;
  assign desc.start = DESC_IDX_W'(s_f);
  assign desc.len   = DESC_LEN_W'(strip);
  assign desc.pos   = pos + POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_tok <= 1'b0;
      tok_len    <= '0;
      have_na    <= 1'b0;
      s_idx      <= '0;
      e_idx      <= '0;
      wr_half    <= 1'b0;
      pos        <= '0;
      busy       <= '0;
    end else begin
      if (accept) begin
        if (fin) begin
          inside_tok <= 1'b0;
          tok_len    <= '0;
        end else if (word) begin
          inside_tok <= 1'b1;
          tok_len    <= l_new;
          have_na    <= have_new;
          s_idx      <= s_new;
          e_idx      <= e_new;
        end
      end
      pos <= pos + POS_W'(emit) + POS_W'(bump);
      if (emit) begin
        wr_half <= !wr_half;
      end
      // set and release never hit the same half in one cycle
      if (rel.valid) begin
        busy[rel.half] <= 1'b0;
      end
      if (emit) begin
        busy[wr_half] <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/awt_queue.sv
// awt_queue: two-entry queue of token descriptors between front and back.
// Depends on awt_pkg.
module awt_queue import awt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t din,
  input  logic  pop,
  output logic  q_valid,
  output desc_t head
);

  desc_t      entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign q_valid = count != 2'd0;
  assign head    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/awt_back.sv
// awt_back: streams queued tokens out of the buffer RAM one byte per cycle
// while the output is not stalled, with a read-data stage and an output register;
// frees buffer halves. Depends on awt_pkg.
module awt_back import awt_pkg::*; #(
  parameter int MAX_TOKEN = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  desc_t                      head,
  output logic                       pop,
  output logic                       ram_re,
  output logic [$clog2(MAX_TOKEN):0] ram_raddr,
  input  logic [CFG_W-1:0]           ram_rdata,
  output rel_t                       rel,
  output logic                       token_valid,
  input  logic                       token_stall,
  output logic [CFG_W-1:0]           token_byte,
  output logic [POS_W-1:0]           token_position,
  output logic                       last_byte
);

  localparam int IDXW = $clog2(MAX_TOKEN);
  localparam int LENW = $clog2(MAX_TOKEN + 1);

  logic [LENW-1:0]  rem;
  logic [IDXW-1:0]  cur_idx;
  logic             cur_half;
  logic [POS_W-1:0] cur_pos;

  logic             rvalid, r_last, r_half;
  logic [POS_W-1:0] r_pos;
  logic             o_half;

  logic             active, out_take, consume, free;
  logic [IDXW-1:0]  idx_i;
  logic [LENW-1:0]  rem_i;
  logic             half_i;
  logic [POS_W-1:0] pos_i;

  assign out_take = token_valid && !token_stall;
  assign consume  = rvalid && (!token_valid || !token_stall);
  assign free     = !rvalid || consume;
  assign active   = rem != '0;

  always_comb begin
    if (active) begin
      idx_i  = cur_idx;
      rem_i  = rem;
      half_i = cur_half;
      pos_i  = cur_pos;
    end else begin
      idx_i  = head.start[IDXW-1:0];
      rem_i  = head.len[LENW-1:0];
      half_i = head.half;
      pos_i  = head.pos;
    end
  end

  assign ram_re    = free && (active || q_valid);
  assign pop       = ram_re && !active;
  assign ram_raddr = {half_i, idx_i};

  assign rel.valid = out_take && last_byte;
  assign rel.half  = o_half;

  always_ff @(posedge clk) begin
    if (ram_re) begin
      cur_idx  <= idx_i + IDXW'(1);
      cur_half <= half_i;
      cur_pos  <= pos_i;
      r_last   <= rem_i == LENW'(1);
      r_half   <= half_i;
      r_pos    <= pos_i;
    end
    if (consume) begin
      token_byte     <= ram_rdata;
      token_position <= r_pos;
      last_byte      <= r_last;
      o_half         <= r_half;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem         <= '0;
      rvalid      <= 1'b0;
      token_valid <= 1'b0;
    end else begin
      if (ram_re) begin
        rem <= rem_i - LENW'(1);
      end
      if (ram_re) begin
        rvalid <= 1'b1;
      end else if (consume) begin
        rvalid <= 1'b0;
      end
      if (consume) begin
        token_valid <= 1'b1;
      end else if (out_take) begin
        token_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/ascii_word_tokenizer.sv
// ascii_word_tokenizer: lowercases an ASCII stream and emits word tokens.
// Input: one character per cycle; it stalls only while both token buffers hold
// tokens not yet streamed out. Output: one token byte per cycle while token_stall is low.
// Once its ending character is taken, a token is queued, read from the RAM and registered at the output.
// Synchronous reset clears control state and config; the buffer RAM is not cleared.
// Depends on awt_pkg, awt_ram, awt_front, awt_queue, awt_back.
module ascii_word_tokenizer import awt_pkg::*; #(
  parameter int MAX_TOKEN = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 char_valid,
  output logic                 char_stall,
  input  logic [CFG_W-1:0]     char_code,
  input  logic                 end_of_text,
  output logic                 token_valid,
  input  logic                 token_stall,
  output logic [CFG_W-1:0]     token_byte,
  output logic [POS_W-1:0]     token_position,
  output logic                 last_byte
);

  localparam int AW = $clog2(MAX_TOKEN) + 1;

  cfg_t                 cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [CFG_W-1:0]     ram_wdata, ram_rdata;
  logic                 push, pop, q_valid;
  desc_t                desc, head;
  rel_t                 rel;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_len <= MIN_LEN_RST;
      cfg.max_len <= MAX_LEN_RST;
      cfg.bumper  <= BUMPER_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MIN_LEN: cfg.min_len <= pwdata[CFG_W-1:0];
        REG_MAX_LEN: cfg.max_len <= pwdata[CFG_W-1:0];
        REG_BUMPER:  cfg.bumper  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_LEN: prdata = 32'(cfg.min_len);
      REG_MAX_LEN: prdata = 32'(cfg.max_len);
      REG_BUMPER:  prdata = 32'(cfg.bumper);
      default:     prdata = '0;
    endcase
  end

  awt_front #(.MAX_TOKEN(MAX_TOKEN)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .push        (push),
    .desc        (desc),
    .rel         (rel)
  );

  // two halves: one being filled, one being streamed
  awt_ram #(.WIDTH(CFG_W), .DEPTH(2 ** AW)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  awt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .din     (desc),
    .pop     (pop),
    .q_valid (q_valid),
    .head    (head)
  );

  awt_back #(.MAX_TOKEN(MAX_TOKEN)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .rel            (rel),
    .token_valid    (token_valid),
    .token_stall    (token_stall),
    .token_byte     (token_byte),
    .token_position (token_position),
    .last_byte      (last_byte)
  );

endmodule

// File: rtl/awt_checker.sv
// awt_checker: port-level checks of the tokenizer output and config port,
// bound to the top level. Depends on awt_pkg.
module awt_checker import awt_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             token_valid,
  input logic             token_stall,
  input logic [CFG_W-1:0] token_byte,
  input logic [POS_W-1:0] token_position,
  input logic             last_byte,
  input logic [31:0]      prdata,
  input logic             pready
);

  logic             mid;      // inside a token on the output side
  logic [POS_W-1:0] mid_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= 1'b0;
    end else if (token_valid && !token_stall) begin
      mid <= !last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (token_valid && !token_stall) begin
      mid_pos <= token_position;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> token_valid && $stable(token_byte) &&
      $stable(token_position) && $stable(last_byte))
    else $error("output transaction changed while stalled");

  a_pos_in_token: assert property (@(posedge clk) disable iff (rst)
    token_valid && mid |-> token_position == mid_pos)
    else $error("position changed inside a token");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !token_valid)
    else $error("output valid right after reset");

  a_cfg_read: assert property (@(posedge clk) disable iff (rst)
    pready && prdata[31:CFG_W] == '0)
    else $error("config read out of range");

endmodule

bind ascii_word_tokenizer awt_checker u_awt_checker (
  .clk            (clk),
  .rst            (rst),
  .token_valid    (token_valid),
  .token_stall    (token_stall),
  .token_byte     (token_byte),
  .token_position (token_position),
  .last_byte      (last_byte),
  .prdata         (prdata),
  .pready         (pready)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for ascii_word_tokenizer; a directed script, then random text phases.
// Every token byte is checked against an in-bench tokenizer. Depends on awt_pkg and the RTL.
module tb;
  import awt_pkg::*;

  localparam int TOKEN_CAP   = 64;
  localparam int DRAIN_WAIT  = 10;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 40;
  localparam int N_SCRIPT    = 36;
  localparam int N_PHASES    = 8;

  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped, writes are dropped

  typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [CFG_W-1:0] tbyte;
    logic [POS_W-1:0] pos;
    logic             last;
  } tok_byte_t;

  typedef struct packed {
    row_kind_e            kind;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     code;      // character, or register value
    logic                 eot;
    int                   n_exp;     // bytes emitted; -1 leaves it to the model
    logic [CFG_W-1:0]     exp_byte;  // final byte of the token
    logic [POS_W-1:0]     exp_pos;
  } script_row_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_len;
    logic [CFG_W-1:0] max_len;
    logic [CFG_W-1:0] bump;
    idle_mode_e       mode;
    int               long_pct;
    logic             hold;
  } phase_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [3:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             char_valid = 1'b0;
  logic             char_stall;
  logic [CFG_W-1:0] char_code = '0;
  logic             end_of_text = 1'b0;
  logic             token_valid;
  logic             token_stall = 1'b0;
  logic [CFG_W-1:0] token_byte;
  logic [POS_W-1:0] token_position;
  logic             last_byte;

  // tokenizer model state
  logic [CFG_W-1:0] cfg_min = MIN_LEN_RST;
  logic [CFG_W-1:0] cfg_max = MAX_LEN_RST;
  logic [CFG_W-1:0] cfg_bump = BUMPER_RST;
  logic [CFG_W-1:0] tok_buf [TOKEN_CAP];
  int               tok_len = 0;
  logic             in_tok = 1'b0;
  logic [POS_W-1:0] pos_cnt = '0;

  tok_byte_t pending_bytes [$];
  int        mismatch_count = 0;
  int        chars_taken = 0;
  int        quiet_cycles = 0;
  int        send_gap_pct = 0;
  int        stall_pct = 0;
  int        hold_req = 0;
  int        hold_left = 0;

  script_row_t script [N_SCRIPT] = '{
    '{ROW_CHAR, REG_MIN_LEN, 7'h41, 1'b1,  1, 7'h61, 32'd1},  // "A" alone at end of text
    '{ROW_CHAR, REG_MIN_LEN, 7'h27, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h5A, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h39, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h27, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h00, 1'b0,  2, 7'h39, 32'd2},  // NUL ends 'z9', quotes stripped
    '{ROW_CHAR, REG_MIN_LEN, 7'h27, 1'b1,  0, 7'h00, 32'd0},  // lone quote strips to nothing
    '{ROW_CHAR, REG_MIN_LEN, 7'h7F, 1'b1,  0, 7'h00, 32'd0},  // DEL, end of text, no token
    '{ROW_CHAR, REG_MIN_LEN, 7'h30, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h20, 1'b1,  1, 7'h30, 32'd3},  // end of text on a separator
    '{ROW_CFG,  REG_BUMPER,  7'h2D, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h2D, 1'b0,  0, 7'h00, 32'd0},  // bump to 4
    '{ROW_CHAR, REG_MIN_LEN, 7'h62, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h2D, 1'b0,  1, 7'h62, 32'd5},  // emit, then bump
    '{ROW_CFG,  REG_BUMPER,  7'h78, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h78, 1'b1,  1, 7'h78, 32'd7},  // word char as bumper
    '{ROW_CFG,  REG_BUMPER,  7'h00, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CFG,  REG_MIN_LEN, 7'h03, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h61, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h62, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h2E, 1'b0,  0, 7'h00, 32'd0},  // too short
    '{ROW_CFG,  REG_MIN_LEN, 7'h01, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CFG,  REG_MAX_LEN, 7'h02, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h63, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h44, 1'b0,  2, 7'h64, 32'd9},  // cut at max_len
    '{ROW_CHAR, REG_MIN_LEN, 7'h65, 1'b1,  1, 7'h65, 32'd10},
    '{ROW_CFG,  REG_MAX_LEN, 7'h00, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h71, 1'b0,  1, 7'h71, 32'd11}, // zero max_len acts as one
    '{ROW_CFG,  REG_MAX_LEN, 7'h40, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h61, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h62, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CHAR, REG_MIN_LEN, 7'h63, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CFG,  REG_MAX_LEN, 7'h02, 1'b0, -1, 7'h00, 32'd0},  // lowered with a token open
    '{ROW_CHAR, REG_MIN_LEN, 7'h64, 1'b0,  4, 7'h64, 32'd12},
    '{ROW_CFG,  REG_SPARE,   7'h05, 1'b0, -1, 7'h00, 32'd0},
    '{ROW_CFG,  REG_MAX_LEN, 7'h40, 1'b0, -1, 7'h00, 32'd0}
  };

  phase_t plan [N_PHASES] = '{
    '{7'd1,   7'd64,  7'h00, IDLE_NONE, 5,  1'b0},
    '{7'd0,   7'd127, 7'h20, IDLE_SEND, 5,  1'b0},
    '{7'd127, 7'd5,   7'h00, IDLE_RECV, 5,  1'b0},  // nothing long enough to emit
    '{7'd2,   7'd8,   7'h61, IDLE_BOTH, 5,  1'b0},
    '{7'd1,   7'd1,   7'h27, IDLE_NONE, 0,  1'b1},  // output held off, input backs up
    '{7'd64,  7'd127, 7'h00, IDLE_SEND, 40, 1'b0},
    '{7'd3,   7'd16,  7'h2D, IDLE_RECV, 10, 1'b0},
    '{7'd1,   7'd64,  7'h65, IDLE_BOTH, 10, 1'b0}
  };

  ascii_word_tokenizer u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [CFG_W-1:0] lower_char(input logic [CFG_W-1:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) ? (c | CASE_BIT) : c;
  endfunction

  function automatic logic is_word_char(input logic [CFG_W-1:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_D0 && c <= CH_D9) || c == CH_APOS;
  endfunction

  // Strip quotes, emit if long enough, close the token. Returns bytes queued.
  function automatic int close_word();
    int s;
    int e;
    int len;
    int eff_min;
    tok_byte_t item;
    s = 0;
    e = tok_len;
    while (s < e && tok_buf[s] == CH_APOS) s++;
    while (e > s && tok_buf[e-1] == CH_APOS) e--;
    len = e - s;
    eff_min = (cfg_min == '0) ? 1 : int'(cfg_min);
    if (len > 0 && len >= eff_min) begin
      pos_cnt++;
      for (int k = 0; k < len; k++) begin
        item.tbyte = tok_buf[s+k];
        item.pos   = pos_cnt;
        item.last  = (k == len - 1);
        pending_bytes.push_back(item);
      end
    end else begin
      len = 0;
    end
    in_tok  = 1'b0;
    tok_len = 0;
    return len;
  endfunction

  function automatic int tokenize_char(input logic [CFG_W-1:0] code, input logic eot);
    logic [CFG_W-1:0] c;
    int lim;
    int n;
    c   = lower_char(code);
    lim = int'(cfg_max);
    n   = 0;
    if (lim < 1) lim = 1;
    if (lim > TOKEN_CAP) lim = TOKEN_CAP;
    if (is_word_char(c)) begin
      if (!in_tok) begin
        in_tok  = 1'b1;
        tok_len = 0;
      end
      if (tok_len < TOKEN_CAP) begin
        tok_buf[tok_len] = c;
        tok_len++;
      end
      if (tok_len >= lim || eot) n = close_word();
    end else if (in_tok) begin
      n = close_word();
    end
    // bumper applies after any emission on this character
    if (cfg_bump != '0 && c == cfg_bump) pos_cnt++;
    return n;
  endfunction

  function automatic logic [CFG_W-1:0] pick_word_char();
    int r;
    r = int'($urandom_range(99));
    if (r < 10) return CH_APOS;
    if (r < 40) return CH_UP_A + 7'($urandom_range(25));
    if (r < 80) return CH_LO_A + 7'($urandom_range(25));
    return CH_D0 + 7'($urandom_range(9));
  endfunction

  function automatic logic [CFG_W-1:0] pick_gap_char(input logic [CFG_W-1:0] bump);
    logic [CFG_W-1:0] c;
    if (bump != '0 && !is_word_char(bump) && $urandom_range(99) < 20) return bump;
    do c = 7'($urandom_range(127)); while (is_word_char(lower_char(c)));
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
    mismatch_count++;
  endtask

  task automatic send_char(input logic [CFG_W-1:0] code, input logic eot, output int made);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid  <= 1'b1;
    char_code   <= code;
    end_of_text <= eot;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    made = tokenize_char(code, eot);
    chars_taken++;
    @(negedge clk);
  endtask

  // Wait until every queued byte is out, plus the pipeline latency.
  task automatic settle_outputs();
    char_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {25'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MIN_LEN: cfg_min  = val;
      REG_MAX_LEN: cfg_max  = val;
      REG_BUMPER:  cfg_bump = val;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // output side: stall pattern, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      token_stall <= 1'b1;
    end else begin
      token_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    tok_byte_t want;
    if (!rst && token_valid && !token_stall) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("token byte with nothing pending", 32'(token_byte), 32'd0);
      end else begin
        want = pending_bytes.pop_front();
        if (token_byte !== want.tbyte)
          report_mismatch("token_byte", 32'(token_byte), 32'(want.tbyte));
        if (token_position !== want.pos)
          report_mismatch("token_position", token_position, want.pos);
        if (last_byte !== want.last)
          report_mismatch("last_byte", 32'(last_byte), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (char_valid && !char_stall) || (token_valid && !token_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    int base;
    int len;
    logic eot_flag;
    tok_byte_t tail;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_SCRIPT; i++) begin
      if (script[i].kind == ROW_CFG) begin
        settle_outputs();
        write_reg(script[i].reg_idx, script[i].code);
      end else begin
        send_char(script[i].code, script[i].eot, n);
        if (script[i].n_exp >= 0) begin
          if (n != script[i].n_exp) begin
            report_mismatch($sformatf("model byte count, row %0d", i), n, script[i].n_exp);
          end else if (n > 0) begin
            tail = pending_bytes[$];
            if (tail.tbyte != script[i].exp_byte)
              report_mismatch($sformatf("model last byte, row %0d", i),
                              32'(tail.tbyte), 32'(script[i].exp_byte));
            if (tail.pos != script[i].exp_pos)
              report_mismatch($sformatf("model position, row %0d", i),
                              tail.pos, script[i].exp_pos);
          end
        end
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      settle_outputs();
      write_reg(REG_MIN_LEN, plan[p].min_len);
      write_reg(REG_MAX_LEN, plan[p].max_len);
      write_reg(REG_BUMPER, plan[p].bump);
      case (plan[p].mode)
        IDLE_NONE: begin send_gap_pct = 0;  stall_pct = 0;  end
        IDLE_SEND: begin send_gap_pct = 86; stall_pct = 0;  end
        IDLE_RECV: begin send_gap_pct = 0;  stall_pct = 86; end
        default:   begin send_gap_pct = 27; stall_pct = 27; end
      endcase
      if (plan[p].hold) hold_req = HOLD_CYCLES;
      base = chars_taken;
      while (chars_taken - base < PHASE_ITEMS) begin
        if ($urandom_range(99) < 15) begin
          // noise: any code, any flag
          send_char(7'($urandom_range(127)), 1'($urandom_range(1)), n);
        end else begin
          if ($urandom_range(99) < plan[p].long_pct) len = int'($urandom_range(70, 9));
          else len = int'($urandom_range(8, 1));
          eot_flag = ($urandom_range(9) == 0);
          for (int k = 0; k < len; k++)
            send_char(pick_word_char(), eot_flag && k == len - 1, n);
          if (!eot_flag)
            send_char(pick_gap_char(plan[p].bump), ($urandom_range(7) == 0), n);
        end
      end
    end

    settle_outputs();
    if (pending_bytes.size() != 0)
      report_mismatch("token bytes never produced", pending_bytes.size(), 32'd0);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
